/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// plain property, checked on every rising edge outside reset
`define MTS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// overlapping implication
`define MTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`else

`define MTS_ASSERT(lbl, clk, rst_n, prop)
`define MTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* src/mts_pkg.sv */
// ----------------------------------------------------------------------------
// mts_pkg
// Shared constants and types of the min tracking stack
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] data_t;

  localparam cnt_t FULL_COUNT = cnt_t'(STACK_DEPTH);

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic                     is_empty;
    status_t                  status;
  } res_t;

  typedef struct packed {
    logic  we;
    logic  re;
    addr_t addr;
    data_t wdata;
  } ram_req_t;

endpackage

`default_nettype wire

/* src/mts_if.sv */
// ----------------------------------------------------------------------------
// mts_if
// Valid/ready channels for stack operations and results
// ----------------------------------------------------------------------------
`default_nettype none

interface mts_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic signed [31:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface mts_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] top_value;
  logic signed [31:0] min_value;
  logic        is_empty;
  logic [1:0]  status;

  modport source (output valid, output top_value, output min_value, output is_empty,
                  output status, input ready);
  modport sink   (input valid, input top_value, input min_value, input is_empty,
                  input status, output ready);
endinterface

`default_nettype wire

/* src/mts_ram.sv */
// ----------------------------------------------------------------------------
// mts_ram
// Single port synchronous RAM, registered read data held between reads
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* src/mts_ctrl.sv */
// ----------------------------------------------------------------------------
// mts_ctrl
// Stack control: counters, cached tops and access sequencing of both stores
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_mode,
  input  wire logic signed [31:0]  in_value,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output mts_pkg::res_t            res,
  output mts_pkg::ram_req_t        vram_req,
  input  wire mts_pkg::data_t      vram_rdata,
  output mts_pkg::ram_req_t        mram_req,
  input  wire mts_pkg::data_t      mram_rdata
);

  typedef enum logic {
    S_IDLE,
    S_FIN
  } state_t;

  state_t               state_r,  state_nxt;
  mts_pkg::cnt_t        fill_r,   fill_nxt;
  mts_pkg::cnt_t        minc_r,   minc_nxt;
  mts_pkg::data_t       top_r,    top_nxt;
  mts_pkg::data_t       min_r,    min_nxt;
  mts_pkg::status_t     status_r, status_nxt;
  logic                 pop_r,    pop_nxt;
  logic                 popmin_r, popmin_nxt;

  mts_pkg::data_t       cur_top;
  mts_pkg::data_t       cur_min;
  logic                 empty;

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    minc_nxt   = minc_r;
    top_nxt    = top_r;
    min_nxt    = min_r;
    status_nxt = status_r;
    pop_nxt    = pop_r;
    popmin_nxt = popmin_r;
    vram_req   = '0;
    mram_req   = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt  = S_FIN;
          status_nxt = mts_pkg::ST_OK;
          pop_nxt    = 1'b0;
          popmin_nxt = 1'b0;
          if (in_mode == mts_pkg::MODE_PUSH) begin
            if (fill_r == mts_pkg::FULL_COUNT) begin
              status_nxt = mts_pkg::ST_FULL;
            end else begin
              vram_req.we    = 1'b1;
              vram_req.addr  = fill_r[mts_pkg::ADDR_W-1:0];
              vram_req.wdata = in_value;
              fill_nxt       = fill_r + mts_pkg::cnt_t'(1);
              top_nxt        = in_value;
              if (minc_r == '0 || in_value <= $signed(min_r)) begin
                mram_req.we    = 1'b1;
                mram_req.addr  = minc_r[mts_pkg::ADDR_W-1:0];
                mram_req.wdata = in_value;
                minc_nxt       = minc_r + mts_pkg::cnt_t'(1);
                min_nxt        = in_value;
              end
            end
          end else begin
            if (fill_r == '0) begin
              status_nxt = mts_pkg::ST_EMPTY;
            end else begin
              // fetch the entry that becomes the new top
              fill_nxt      = fill_r - mts_pkg::cnt_t'(1);
              pop_nxt       = 1'b1;
              vram_req.re   = 1'b1;
              vram_req.addr = mts_pkg::addr_t'(fill_r - mts_pkg::cnt_t'(2));
              if (minc_r != '0 && top_r == min_r) begin
                popmin_nxt    = 1'b1;
                minc_nxt      = minc_r - mts_pkg::cnt_t'(1);
                mram_req.re   = 1'b1;
                mram_req.addr = mts_pkg::addr_t'(minc_r - mts_pkg::cnt_t'(2));
              end
            end
          end
        end
      end
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
          top_nxt   = cur_top;
          min_nxt   = cur_min;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // read data only matters when this op popped the matching stack
  assign cur_top = pop_r    ? vram_rdata : top_r;
  assign cur_min = popmin_r ? mram_rdata : min_r;
  assign empty   = (fill_r == '0);

  always_comb begin
    res.top_value = empty ? '0 : cur_top;
    res.min_value = (empty || minc_r == '0) ? '0 : cur_min;
    res.is_empty  = empty;
    res.status    = status_r;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      minc_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      minc_r  <= minc_nxt;
    end
    top_r    <= top_nxt;
    min_r    <= min_nxt;
    status_r <= status_nxt;
    pop_r    <= pop_nxt;
    popmin_r <= popmin_nxt;
  end

endmodule

`default_nettype wire

/* src/mts_out.sv */
// ----------------------------------------------------------------------------
// mts_out
// Result register between the stack control and the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module mts_out (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          res_valid,
  output logic               res_ready,
  input  wire mts_pkg::res_t res,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mts_pkg::res_t      out_res
);

  logic          valid_r;
  mts_pkg::res_t data_r;

  // free when empty or being drained in this cycle
  assign res_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = data_r;

endmodule

`default_nettype wire

/* src/min_tracking_stack.sv */
// ----------------------------------------------------------------------------
// min_tracking_stack
// Stack of signed 32-bit values that reports its top and its minimum
// ----------------------------------------------------------------------------
// in_ch carries one operation per transfer: mode 0 pushes value, mode 1 pops.
// out_ch returns one result per operation: top, minimum, empty flag and
// status (ok, push refused on full, pop ignored on empty), top and minimum
// reading 0 while empty.
// Values and candidate minima live in two single port RAMs of STACK_DEPTH
// words; the current tops of both stacks are cached in registers.
// The transfer cycle writes the pushed value or issues the RAM reads of the
// entries under the tops; the next cycle takes the read data and loads the
// result register, or waits while it cannot take it. A new operation is
// taken only after the result of the last one has gone into the register.
// Reset clears both counts, so the stack is empty at once with no clearing
// pass; popping the last entry reads a word that may never have been written,
// and the empty flag masks it.
// While out_ch stalls the result register holds one result and a second one
// waits in the control; in_ch.ready stays low until the register drains.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module min_tracking_stack (
  input  wire logic clk,
  input  wire logic rst_n,
  mts_in_if.sink    in_ch,
  mts_out_if.source out_ch
);

  logic              res_valid;
  logic              res_ready;
  mts_pkg::res_t     res;
  mts_pkg::res_t     out_res;
  mts_pkg::ram_req_t vram_req;
  mts_pkg::ram_req_t mram_req;
  mts_pkg::data_t    vram_rdata;
  mts_pkg::data_t    mram_rdata;

  mts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_mode    (in_ch.mode),
    .in_value   (in_ch.value),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .vram_req   (vram_req),
    .vram_rdata (vram_rdata),
    .mram_req   (mram_req),
    .mram_rdata (mram_rdata)
  );

  mts_ram #(
    .DEPTH (mts_pkg::STACK_DEPTH),
    .WIDTH (mts_pkg::DATA_W)
  ) u_value_ram (
    .clk   (clk),
    .we    (vram_req.we),
    .re    (vram_req.re),
    .addr  (vram_req.addr),
    .wdata (vram_req.wdata),
    .rdata (vram_rdata)
  );

  mts_ram #(
    .DEPTH (mts_pkg::STACK_DEPTH),
    .WIDTH (mts_pkg::DATA_W)
  ) u_minima_ram (
    .clk   (clk),
    .we    (mram_req.we),
    .re    (mram_req.re),
    .addr  (mram_req.addr),
    .wdata (mram_req.wdata),
    .rdata (mram_rdata)
  );

  mts_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.top_value = out_res.top_value;
  assign out_ch.min_value = out_res.min_value;
  assign out_ch.is_empty  = out_res.is_empty;
  assign out_ch.status    = out_res.status;

  // an empty stack reports zero for both values
  `MTS_ASSERT_IMPL(a_empty_zero, clk, rst_n, out_ch.valid && out_ch.is_empty, out_ch.top_value == '0 && out_ch.min_value == '0)

  // a refused push means the stack was full, so never empty
  `MTS_ASSERT_IMPL(a_full_not_empty, clk, rst_n, out_ch.valid && out_ch.status == mts_pkg::ST_FULL, !out_ch.is_empty)

  // the tracked minimum never exceeds the top
  `MTS_ASSERT_IMPL(a_min_le_top, clk, rst_n, out_ch.valid && !out_ch.is_empty, out_ch.min_value <= out_ch.top_value)

  // every accepted operation holds the input side off right after its transfer
  `MTS_ASSERT(a_two_cycle, clk, rst_n, in_ch.valid && in_ch.ready |=> !in_ch.ready)

endmodule

`default_nettype wire

/* tb/min_tracking_stack_tb.sv */
// ----------------------------------------------------------------------------
// min_tracking_stack_tb
// Self-checking bench for the stack with running minimum
// ----------------------------------------------------------------------------
// Pushes and pops go in over in_ch. Each accepted operation is applied to a
// behavioral copy of both stacks, and the result that copy predicts is
// queued. Every result taken from out_ch must match the oldest queued
// prediction in each field.
// The tests cover pops on an empty stack, extreme and repeated values, a
// random mix of operations and a fill to full depth with refused pushes.
// Both channels stall at random, except in one long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module min_tracking_stack_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int RANDOM_OPS     = 200;
  localparam int FULL_DRAIN_OPS = 16;

  logic clk;
  logic rst_n;
  logic no_idle;
  int   cycle_count;
  int   fail_count;

  mts_in_if  in_ch ();
  mts_out_if out_ch ();

  min_tracking_stack u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // behavioral copy of the stack state
  logic signed [mts_pkg::DATA_W-1:0] value_mem  [mts_pkg::STACK_DEPTH];
  logic signed [mts_pkg::DATA_W-1:0] minima_mem [mts_pkg::STACK_DEPTH];
  int            value_cnt;
  int            minima_cnt;
  mts_pkg::res_t pending_results [$];

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: ready drops about one cycle in ten
  always @(negedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 10);
  end

  // apply one accepted operation and queue the result it should produce
  function automatic void apply_stack_op(logic mode,
                                         logic signed [mts_pkg::DATA_W-1:0] value);
    mts_pkg::res_t res;
    res.status = mts_pkg::ST_OK;
    if (mode == mts_pkg::MODE_PUSH) begin
      if (value_cnt >= mts_pkg::STACK_DEPTH) begin
        res.status = mts_pkg::ST_FULL;
      end else begin
        value_mem[value_cnt] = value;
        value_cnt++;
        if (minima_cnt == 0 || value <= minima_mem[minima_cnt-1]) begin
          minima_mem[minima_cnt] = value;
          minima_cnt++;
        end
      end
    end else begin
      if (value_cnt == 0) begin
        res.status = mts_pkg::ST_EMPTY;
      end else begin
        // the candidate goes only when the removed value is the minimum
        if (minima_cnt > 0 && value_mem[value_cnt-1] == minima_mem[minima_cnt-1])
          minima_cnt--;
        value_cnt--;
      end
    end
    res.top_value = '0;
    res.min_value = '0;
    res.is_empty  = 1'b1;
    if (value_cnt > 0) begin
      res.top_value = value_mem[value_cnt-1];
      res.is_empty  = 1'b0;
      if (minima_cnt > 0)
        res.min_value = minima_mem[minima_cnt-1];
    end
    pending_results.push_back(res);
  endfunction

  always @(posedge clk) begin
    mts_pkg::res_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no prediction waiting");
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_ch.top_value !== exp_res.top_value) begin
          $error("top_value: expected %0d, got %0d", exp_res.top_value, out_ch.top_value);
          fail_count++;
        end
        if (out_ch.min_value !== exp_res.min_value) begin
          $error("min_value: expected %0d, got %0d", exp_res.min_value, out_ch.min_value);
          fail_count++;
        end
        if (out_ch.is_empty !== exp_res.is_empty) begin
          $error("is_empty: expected %0d, got %0d", exp_res.is_empty, out_ch.is_empty);
          fail_count++;
        end
        if (out_ch.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_ch.status);
          fail_count++;
        end
      end
    end
  end

  // one operation; returns right after the transfer edge, valid still high
  task automatic issue_op(logic mode, logic signed [mts_pkg::DATA_W-1:0] value);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 10) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_stack_op(mode, value);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // small values repeat often, which exercises pops of equal minima
  function automatic logic signed [mts_pkg::DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40)
      return $signed($urandom_range(0, 16)) - 8;
    if (sel < 60) begin
      case ($urandom_range(0, 5))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh8000_0001;
        3: return 32'sh7fff_fffe;
        4: return -1;
        default: return 0;
      endcase
    end
    return $signed($urandom());
  endfunction

  task automatic test_empty_pops();
    issue_op(mts_pkg::MODE_POP, $signed($urandom()));
    issue_op(mts_pkg::MODE_POP, 32'sh7fff_ffff);
    issue_op(mts_pkg::MODE_PUSH, 42);
    issue_op(mts_pkg::MODE_POP, $signed($urandom()));
    issue_op(mts_pkg::MODE_POP, 32'sh8000_0000);
    release_input();
  endtask

  task automatic test_extremes();
    issue_op(mts_pkg::MODE_PUSH, 32'sh7fff_ffff);
    issue_op(mts_pkg::MODE_PUSH, 5);
    issue_op(mts_pkg::MODE_PUSH, 3);
    issue_op(mts_pkg::MODE_PUSH, 3);
    issue_op(mts_pkg::MODE_PUSH, 9);
    issue_op(mts_pkg::MODE_POP, -1);
    // removing one of two equal minima keeps the other
    issue_op(mts_pkg::MODE_POP, 0);
    issue_op(mts_pkg::MODE_POP, 0);
    issue_op(mts_pkg::MODE_PUSH, 32'sh8000_0000);
    issue_op(mts_pkg::MODE_PUSH, 32'sh8000_0000);
    issue_op(mts_pkg::MODE_PUSH, -1);
    issue_op(mts_pkg::MODE_PUSH, 0);
    repeat (7) issue_op(mts_pkg::MODE_POP, $signed($urandom()));
    release_input();
  endtask

  task automatic test_full_stack();
    while (value_cnt < mts_pkg::STACK_DEPTH)
      issue_op(mts_pkg::MODE_PUSH, pick_value());
    // refused pushes must leave both stacks alone, even with a new minimum
    issue_op(mts_pkg::MODE_PUSH, 32'sh8000_0000);
    issue_op(mts_pkg::MODE_PUSH, 32'sh7fff_ffff);
    issue_op(mts_pkg::MODE_POP, 0);
    issue_op(mts_pkg::MODE_PUSH, 32'sh8000_0000);
    issue_op(mts_pkg::MODE_PUSH, -5);
    repeat (FULL_DRAIN_OPS) issue_op(mts_pkg::MODE_POP, $signed($urandom()));
    release_input();
  endtask

  task automatic test_random_ops();
    int push_pct;
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i % 50 == 0)
        push_pct = $urandom_range(0, 2) * 20 + 30;
      no_idle = (i >= 60 && i < 160);
      if ($urandom_range(0, 99) < push_pct)
        issue_op(mts_pkg::MODE_PUSH, pick_value());
      else
        issue_op(mts_pkg::MODE_POP, $signed($urandom()));
    end
    no_idle = 1'b0;
    release_input();
  endtask

  initial begin
    rst_n       = 1'b0;
    no_idle     = 1'b0;
    cycle_count = 0;
    fail_count  = 0;
    value_cnt   = 0;
    minima_cnt  = 0;
    in_ch.valid = 1'b0;
    in_ch.mode  = mts_pkg::MODE_PUSH;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_pops();
    test_extremes();
    test_random_ops();
    test_full_stack();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
